// ----- hdl/cbgi_pkg.sv -----
// ---------------------------------------------------------------------------
// cbgi_pkg
// Shared types, constants and helpers of the clamped bilinear grid
// interpolator: grid size, bank geometry, register indexes and item codes.
// ---------------------------------------------------------------------------
package cbgi_pkg;

   // grid size in sample points per axis
   localparam int GRID_POINTS_X = 64;
   localparam int GRID_POINTS_Z = 64;

   // cell index widths
   localparam int CX_W = $clog2(GRID_POINTS_X);
   localparam int CZ_W = $clog2(GRID_POINTS_Z);

   // four banks split by the parity of x and z
   localparam int BANK_X     = (GRID_POINTS_X + 1) / 2;
   localparam int BANK_Z     = (GRID_POINTS_Z + 1) / 2;
   localparam int BANK_DEPTH = BANK_X * BANK_Z;
   localparam int HX_W       = (BANK_X > 1) ? $clog2(BANK_X) : 1;
   localparam int HZ_W       = (BANK_Z > 1) ? $clog2(BANK_Z) : 1;
   localparam int BA_W       = $clog2(BANK_DEPTH);
   localparam int NUM_BANKS  = 4;

   // 1.0 in Q16.16, one bit wider than a weight fraction
   localparam logic [16:0] ONE_Q16 = 17'h10000;

   // rounding bias for the Q16.48 to Q16.16 step
   localparam logic [63:0] ROUND_HALF = 64'h0000_0000_8000_0000;

   // register reset values
   localparam logic [31:0] X_START_RESET = 32'h0000_0000;
   localparam logic [31:0] X_END_RESET   = 32'h003F_0000;
   localparam logic [31:0] Z_START_RESET = 32'h0000_0000;
   localparam logic [31:0] Z_END_RESET   = 32'h003F_0000;
   localparam logic [31:0] X_INV_RESET   = 32'h0001_0000;
   localparam logic [31:0] Z_INV_RESET   = 32'h0001_0000;

   // register indexes
   typedef enum logic [2:0] {
      CSR_X_START = 3'd0,
      CSR_X_END   = 3'd1,
      CSR_Z_START = 3'd2,
      CSR_Z_END   = 3'd3,
      CSR_X_INV   = 3'd4,
      CSR_Z_INV   = 3'd5
   } csr_index_type;

   // item function codes
   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   // stage loads of one axis pipeline
   typedef struct packed {
      logic load_clamp;
      logic load_scale;
   } axis_en_type;

   // address of one sample inside its bank
   function automatic logic [BA_W-1:0] bank_addr(input logic [HX_W-1:0] xh,
                                                  input logic [HZ_W-1:0] zh);
      logic [BA_W+HX_W:0] full;
      full = (BA_W+HX_W+1)'(xh) * (BA_W+HX_W+1)'(BANK_Z) + (BA_W+HX_W+1)'(zh);
      return full[BA_W-1:0];
   endfunction

endpackage

// ----- hdl/cbgi_axis.sv -----
// ---------------------------------------------------------------------------
// cbgi_axis
// One coordinate axis: clamps the coordinate to the grid extent, takes its
// offset from the start and scales it by the reciprocal spacing (Q32.32).
// ---------------------------------------------------------------------------
module cbgi_axis (
   input  logic                      clock,
   input  cbgi_pkg::axis_en_type     en,
   input  logic signed [31:0]        coord,
   input  logic signed [31:0]        lo,
   input  logic signed [31:0]        hi,
   input  logic        [31:0]        inv,
   output logic        [63:0]        pos
);
   import cbgi_pkg::*;

   logic signed [31:0] clamped;
   logic signed [32:0] offset;
   logic        [31:0] dist_in;
   logic        [31:0] dist_ff;
   logic        [63:0] pos_in;
   logic        [63:0] pos_ff;

   // clamp to [lo, hi], raise first then lower, negative offset is zero
   always_comb begin
      clamped = coord;
      if (coord < lo) begin
         clamped = lo;
      end else if (coord > hi) begin
         clamped = hi;
      end
      offset = {clamped[31], clamped} - {lo[31], lo};
      if (offset[32]) begin
         dist_in = 32'd0;
      end else begin
         dist_in = offset[31:0];
      end
   end

   // scaled position, exact 32 x 32 product
   assign pos_in = {32'd0, dist_ff} * {32'd0, inv};

   always_ff @(posedge clock) begin
      if (en.load_clamp) begin
         dist_ff <= dist_in;
      end
      if (en.load_scale) begin
         pos_ff <= pos_in;
      end
   end

   assign pos = pos_ff;

endmodule

// ----- hdl/clamped_bilinear_grid_interpolator_unit.sv -----
// A query beat passes the clamp, scale, locate, weight, product, sum and
// output registers to rsp. One beat per cycle, write or query, while rsp
// is not held; four parity banks give all four cell corners in one read.
// Write beats update the grid and produce no response beat.
// Reset (synchronous): clears the pipeline and restores register defaults;
// grid contents stay undefined until written.
// ---------------------------------------------------------------------------
// clamped_bilinear_grid_interpolator_unit
// Uniform 2-D grid of Q16.16 samples in four banks with a pipelined
// locate, corner fetch, weight and blend path.
// ---------------------------------------------------------------------------
module clamped_bilinear_grid_interpolator_unit (
   input  logic               clock,
   input  logic               reset,
   // request channel
   input  logic               req_valid,
   output logic               req_ready,
   input  logic               req_func,
   input  logic signed [31:0] req_x_coord,
   input  logic signed [31:0] req_z_coord,
   input  logic        [5:0]  req_write_ix,
   input  logic        [5:0]  req_write_iz,
   input  logic signed [31:0] req_write_value,
   // response channel
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_interp_value,
   // register write channel
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic        [2:0]  csr_index,
   input  logic        [31:0] csr_data
);
   import cbgi_pkg::*;

   // configuration registers
   logic signed [31:0] x_start_ff, x_end_ff, z_start_ff, z_end_ff;
   logic        [31:0] x_inv_ff, z_inv_ff;

   // pipeline flow
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, rsp_valid_ff;
   logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6, free_out;

   // stage 1 and 2 write fields
   logic               func1_ff, func2_ff;
   logic        [5:0]  wx1_ff, wz1_ff, wx2_ff, wz2_ff;
   logic signed [31:0] wval1_ff, wval2_ff;

   // axis outputs
   axis_en_type axis_en;
   logic [63:0] pos_x, pos_z;

   // stage 3: locate and corner fetch
   logic [CX_W-1:0] cell_x;
   logic [CZ_W-1:0] cell_z;
   logic [16:0]     t_in, u_in, t3_ff, u3_ff;
   logic            px3_ff, pz3_ff;
   logic [BA_W-1:0] rd_addr [NUM_BANKS];
   logic [31:0]     rdata_ff [NUM_BANKS];
   logic            wr_en;
   logic [1:0]      wr_bank;
   logic [BA_W-1:0] wr_addr;

   // stage 4: weights and ordered corners (00, 10, 11, 01)
   logic [32:0]        w_in [4];
   logic [32:0]        w4_ff [4];
   logic signed [31:0] s4_ff [4];
   logic [16:0]        om_t, om_u;
   logic [33:0]        wp00, wp10, wp11, wp01;

   // stage 5 and 6: products and sums
   logic signed [63:0] prod_in [4];
   logic signed [63:0] prod5_ff [4];
   logic signed [63:0] sum_a_in, sum_b_in, sum_a_ff, sum_b_ff;
   logic        [63:0] total;
   logic signed [31:0] rsp_value_ff;

   // register writes, always accepted
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_start_ff <= X_START_RESET;
         x_end_ff   <= X_END_RESET;
         z_start_ff <= Z_START_RESET;
         z_end_ff   <= Z_END_RESET;
         x_inv_ff   <= X_INV_RESET;
         z_inv_ff   <= Z_INV_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_X_START: x_start_ff <= csr_data;
            CSR_X_END:   x_end_ff   <= csr_data;
            CSR_Z_START: z_start_ff <= csr_data;
            CSR_Z_END:   z_end_ff   <= csr_data;
            CSR_X_INV:   x_inv_ff   <= csr_data;
            CSR_Z_INV:   z_inv_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   // per-stage ready chain, bubbles collapse behind a held response
   assign free_out = !rsp_valid_ff || rsp_ready;
   assign rdy6 = !v6_ff || free_out;
   assign rdy5 = !v5_ff || rdy6;
   assign rdy4 = !v4_ff || rdy5;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign rdy1 = !v1_ff || rdy2;
   assign req_ready = rdy1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy1) v1_ff <= req_valid;
         if (rdy2) v2_ff <= v1_ff;
         if (rdy3) v3_ff <= v2_ff && (func2_ff == FUNC_QUERY);
         if (rdy4) v4_ff <= v3_ff;
         if (rdy5) v5_ff <= v4_ff;
         if (rdy6) v6_ff <= v5_ff;
         if (free_out) rsp_valid_ff <= v6_ff;
      end
   end

   // write fields ride along the locate stages
   always_ff @(posedge clock) begin
      if (rdy1) begin
         func1_ff <= req_func;
         wx1_ff   <= req_write_ix;
         wz1_ff   <= req_write_iz;
         wval1_ff <= req_write_value;
      end
      if (rdy2) begin
         func2_ff <= func1_ff;
         wx2_ff   <= wx1_ff;
         wz2_ff   <= wz1_ff;
         wval2_ff <= wval1_ff;
      end
   end

   // clamp and scale per axis
   assign axis_en.load_clamp = rdy1;
   assign axis_en.load_scale = rdy2;

   cbgi_axis u_axis_x (
      .clock (clock),
      .en    (axis_en),
      .coord (req_x_coord),
      .lo    (x_start_ff),
      .hi    (x_end_ff),
      .inv   (x_inv_ff),
      .pos   (pos_x)
   );

   cbgi_axis u_axis_z (
      .clock (clock),
      .en    (axis_en),
      .coord (req_z_coord),
      .lo    (z_start_ff),
      .hi    (z_end_ff),
      .inv   (z_inv_ff),
      .pos   (pos_z)
   );

   // cell index and weight, upper edge pinned to the last cell with weight 1.0
   always_comb begin
      if (pos_x[63:32] >= 32'(GRID_POINTS_X - 1)) begin
         cell_x = CX_W'(GRID_POINTS_X - 2);
         t_in   = ONE_Q16;
      end else begin
         cell_x = pos_x[32 +: CX_W];
         t_in   = {1'b0, pos_x[31:16]};
      end
      if (pos_z[63:32] >= 32'(GRID_POINTS_Z - 1)) begin
         cell_z = CZ_W'(GRID_POINTS_Z - 2);
         u_in   = ONE_Q16;
      end else begin
         cell_z = pos_z[32 +: CZ_W];
         u_in   = {1'b0, pos_z[31:16]};
      end
   end

   // bank addresses: each bank holds the corner whose parity it owns
   always_comb begin
      logic [CX_W-1:0] xb;
      logic [CZ_W-1:0] zb;
      for (int b = 0; b < NUM_BANKS; b++) begin
         xb = cell_x + CX_W'(cell_x[0] ^ b[1]);
         zb = cell_z + CZ_W'(cell_z[0] ^ b[0]);
         rd_addr[b] = bank_addr(HX_W'(xb >> 1), HZ_W'(zb >> 1));
      end
   end

   // sample write from a write beat in stage 2, ignored outside the grid
   assign wr_en   = rdy3 && v2_ff && (func2_ff == FUNC_WRITE)
                    && (32'(wx2_ff) < 32'(GRID_POINTS_X))
                    && (32'(wz2_ff) < 32'(GRID_POINTS_Z));
   assign wr_bank = {wx2_ff[0], wz2_ff[0]};
   assign wr_addr = bank_addr(HX_W'(wx2_ff >> 1), HZ_W'(wz2_ff >> 1));

   // four grid banks, one read and one write port each
   for (genvar gb = 0; gb < NUM_BANKS; gb++) begin : g_bank
      logic [31:0] bank_mem [BANK_DEPTH];

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == 2'(gb))) begin
            bank_mem[wr_addr] <= wval2_ff;
         end
         if (rdy3) begin
            rdata_ff[gb] <= bank_mem[rd_addr[gb]];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3) begin
         t3_ff  <= t_in;
         u3_ff  <= u_in;
         px3_ff <= cell_x[0];
         pz3_ff <= cell_z[0];
      end
   end

   // corner weights, exact Q1.32
   always_comb begin
      om_t = ONE_Q16 - t3_ff;
      om_u = ONE_Q16 - u3_ff;
      wp00 = {17'd0, om_t} * {17'd0, om_u};
      wp10 = {17'd0, t3_ff} * {17'd0, om_u};
      wp11 = {17'd0, t3_ff} * {17'd0, u3_ff};
      wp01 = {17'd0, om_t} * {17'd0, u3_ff};
      w_in[0] = wp00[32:0];
      w_in[1] = wp10[32:0];
      w_in[2] = wp11[32:0];
      w_in[3] = wp01[32:0];
   end

   // weights and corners sorted out of the banks
   always_ff @(posedge clock) begin
      if (rdy4) begin
         for (int k = 0; k < 4; k++) begin
            w4_ff[k] <= w_in[k];
         end
         s4_ff[0] <= rdata_ff[{px3_ff, pz3_ff}];
         s4_ff[1] <= rdata_ff[{!px3_ff, pz3_ff}];
         s4_ff[2] <= rdata_ff[{!px3_ff, !pz3_ff}];
         s4_ff[3] <= rdata_ff[{px3_ff, !pz3_ff}];
      end
   end

   // weighted corners, each fits 64 bits signed
   always_comb begin
      logic signed [33:0] ws;
      logic signed [65:0] full;
      for (int k = 0; k < 4; k++) begin
         ws = {1'b0, w4_ff[k]};
         full = ws * s4_ff[k];
         prod_in[k] = full[63:0];
      end
   end

   assign sum_a_in = prod5_ff[0] + prod5_ff[1];
   assign sum_b_in = prod5_ff[2] + prod5_ff[3];

   always_ff @(posedge clock) begin
      if (rdy5) begin
         for (int k = 0; k < 4; k++) begin
            prod5_ff[k] <= prod_in[k];
         end
      end
      if (rdy6) begin
         sum_a_ff <= sum_a_in;
         sum_b_ff <= sum_b_in;
      end
   end

   // round half up to Q16.16 into the output register
   assign total = sum_a_ff + sum_b_ff + ROUND_HALF;

   always_ff @(posedge clock) begin
      if (free_out) begin
         rsp_value_ff <= total[63:32];
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_interp_value = rsp_value_ff;

endmodule
